[hw/rtl/ffha_pkg.sv]
// Shared constants for the first-fit heap allocator.
// No dependencies; imported by the allocator top level.
package ffha_pkg;

  localparam int HDR_BYTES = 5;   // header size in bytes
  localparam int START_OFS = 5;   // offset of the first header
  localparam int ADDR_W    = 14;  // width of request and address fields

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

[hw/rtl/ffha_hdr_ram.sv]
// Single-port-write, single-port-read header memory with registered read.
// No dependencies; used by first_fit_heap_allocator.
module ffha_hdr_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator: walks a chain of 5-byte block headers kept in a RAM.
// Each header visited is read and then evaluated; an allocate may then split the block,
// a miss ends at the pool end, and a free writes its header back, merging a free
// successor and a free predecessor, before the result is posted.
// One word at a time: the next word is taken in the cycle after the result posts,
// and posting waits while the previous result is still unaccepted.
// Reset (rst, synchronous): the init state writes the single free block at offset 5;
// only chain headers are ever read, so the rest of the RAM needs no clearing.
// Depends on ffha_pkg and ffha_hdr_ram.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [13:0] request_size, [27:14] block_address, rest zero
  input  logic        s_tuser,   // [0] func (0 allocate, 1 free)
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [13:0] granted_address, [14] success, [15] zero
);
  import ffha_pkg::*;

  // AW indexes the RAM, PW holds a position up to the pool end,
  // WW is wide enough to compare against the 14-bit request fields.
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int LW = AW;
  localparam int PW = AW + 1;
  localparam int WW = ((PW > ADDR_W + 1) ? PW : ADDR_W + 1) + 1;
  localparam logic [WW-1:0] LAST_HDR = WW'(HEAP_BYTES - HDR_BYTES);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_EVAL  = 4'd3;
  localparam logic [3:0] ST_SPLIT = 4'd4;
  localparam logic [3:0] ST_RDN   = 4'd5;
  localparam logic [3:0] ST_NXT   = 4'd6;
  localparam logic [3:0] ST_WRH   = 4'd7;
  localparam logic [3:0] ST_PRV   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]        state;
  logic [PW-1:0]     pos;       // header being visited
  logic [PW-1:0]     nxt;       // successor of the block being freed
  logic [AW-1:0]     prev;      // predecessor header
  logic              has_prev;
  logic              func;
  logic [ADDR_W-1:0] want;
  logic [ADDR_W-1:0] addr;
  logic [WW-1:0]     hpos;      // pos + header, i.e. payload offset
  logic [LW-1:0]     hlen;
  logic [ADDR_W-1:0] res_gnt;
  logic              res_ok;
  logic [ADDR_W-1:0] out_gnt;
  logic              out_ok;
  logic              out_valid;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [AW:0]   ram_rdata;
  logic          rd_free;
  logic [LW-1:0] rd_len;

  // shared header adder: a + HDR_BYTES + b
  logic [WW-1:0] add_a, add_b, add_y;

  logic [WW-1:0] pos_w, want_w, rd_len_w, hlen_w;
  logic          take, split;

  function automatic logic fits(input logic [PW-1:0] p);
    return WW'(p) <= LAST_HDR;
  endfunction

  ffha_hdr_ram #(
    .DEPTH (HEAP_BYTES),
    .WIDTH (AW + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_free  = ram_rdata[AW];
  assign rd_len   = ram_rdata[LW-1:0];
  assign pos_w    = WW'(pos);
  assign want_w   = WW'(want);
  assign rd_len_w = WW'(rd_len);
  assign hlen_w   = WW'(hlen);

  // first fit test and the split rule (remainder must exceed two headers)
  assign take  = rd_free && (rd_len_w >= want_w);
  assign split = rd_len_w > (want_w + WW'(2 * HDR_BYTES));

  always_comb begin
    add_a = pos_w;
    add_b = '0;
    case (state)
      ST_EVAL: begin
        add_b = rd_len_w;
      end
      ST_SPLIT: begin
        add_b = want_w;
      end
      ST_NXT: begin
        add_a = hlen_w;
        add_b = rd_len_w;
      end
      ST_PRV: begin
        add_a = rd_len_w;
        add_b = hlen_w;
      end
      default: begin
        add_a = pos_w;
        add_b = '0;
      end
    endcase
    add_y = add_a + WW'(HDR_BYTES) + add_b;
  end

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = pos[AW-1:0];
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(START_OFS);
        ram_wdata = {1'b1, LW'(HEAP_BYTES - 2 * HDR_BYTES)};
      end
      ST_CHECK: begin
        ram_re = fits(pos);
      end
      ST_EVAL: begin
        if (func == FUNC_ALLOC && take) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, split ? want_w[LW-1:0] : rd_len};
        end
      end
      ST_SPLIT: begin
        // remainder header right after the granted payload
        ram_we    = add_y < WW'(HEAP_BYTES);
        ram_waddr = add_y[AW-1:0];
        ram_wdata = {1'b1, LW'(hlen_w - want_w - WW'(HDR_BYTES))};
      end
      ST_RDN: begin
        ram_re    = fits(nxt);
        ram_raddr = nxt[AW-1:0];
      end
      ST_WRH: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, hlen};
        ram_re    = has_prev;
        ram_raddr = prev;
      end
      ST_PRV: begin
        ram_we    = rd_free;
        ram_waddr = prev;
        ram_wdata = {1'b1, add_y[LW-1:0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
      has_prev  <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (out_valid && m_tready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            func     <= s_tuser;
            want     <= s_tdata[ADDR_W-1:0];
            addr     <= s_tdata[2*ADDR_W-1:ADDR_W];
            pos      <= PW'(START_OFS);
            has_prev <= 1'b0;
            state    <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          hpos <= add_y;
          if (fits(pos)) begin
            state <= ST_EVAL;
          end else begin
            // walk ran off the pool end: no fit / unknown address
            res_gnt <= '0;
            res_ok  <= 1'b0;
            state   <= ST_DONE;
          end
        end
        ST_EVAL: begin
          hlen <= rd_len;
          if (func == FUNC_ALLOC && take) begin
            res_gnt <= hpos[ADDR_W-1:0];
            res_ok  <= 1'b1;
            state   <= split ? ST_SPLIT : ST_DONE;
          end else if (func == FUNC_FREE && hpos == WW'(addr)) begin
            nxt   <= add_y[PW-1:0];
            state <= ST_RDN;
          end else begin
            prev     <= pos[AW-1:0];
            has_prev <= 1'b1;
            pos      <= add_y[PW-1:0];
            state    <= ST_CHECK;
          end
        end
        ST_SPLIT: begin
          state <= ST_DONE;
        end
        ST_RDN: begin
          state <= fits(nxt) ? ST_NXT : ST_WRH;
        end
        ST_NXT: begin
          // absorb a free successor
          if (rd_free) begin
            hlen <= add_y[LW-1:0];
          end
          state <= ST_WRH;
        end
        ST_WRH: begin
          res_gnt <= '0;
          res_ok  <= 1'b1;
          state   <= has_prev ? ST_PRV : ST_DONE;
        end
        ST_PRV: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_gnt   <= res_gnt;
            out_ok    <= res_ok;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_ok, out_gnt};

  // a request keeps the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a word while busy");

  // failed allocates and all frees report address zero
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[14] |-> m_tdata[13:0] == '0)
    else $error("failed result with nonzero address");

  // the sequencer never writes and reads one header in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("header RAM read/write clash");

  // the walk never steps past the pool end
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> WW'(pos) <= WW'(HEAP_BYTES))
    else $error("walk position beyond pool");

endmodule
